/* src/xs_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xs_pkg - shared types and constants of the xoshiro256** generator
// Seeding constants, update amounts and the records passed between the
// request queue, the seeding unit and the generator core.
// ---------------------------------------------------------------------------
package xs_pkg;

	// splitmix64 seeding
	localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;
	localparam int SM_SH1 = 30;
	localparam int SM_SH2 = 27;
	localparam int SM_SH3 = 31;

	// xoshiro256 update and ** scrambler
	localparam int XS_SHIFT = 17;
	localparam int XS_ROT   = 45;
	localparam int SCR_ROT  = 7;

	localparam int WORD_W  = 64;
	localparam int NWORDS  = 4;
	localparam int IDX_W   = 2;

	localparam int QUEUE_DEPTH_DEF = 2;

	// request kinds as carried in tuser
	localparam logic REQ_RESEED = 1'b0;
	localparam logic REQ_NEXT   = 1'b1;

	typedef struct packed {
		logic              is_next;
		logic [WORD_W-1:0] seed;
	} req_t;

	typedef struct packed {
		logic              valid;
		logic              is_next;
		logic [WORD_W-1:0] seed;
	} q_head_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] word;
	} seed_wr_t;

	typedef enum logic [5:0] {
		SD_IDLE  = 6'b000001,
		SD_ADD   = 6'b000010,
		SD_MUL1  = 6'b000100,
		SD_MIX   = 6'b001000,
		SD_MUL2  = 6'b010000,
		SD_STORE = 6'b100000
	} sd_state_t;

endpackage

/* src/xs_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xs_front - request intake and queue
// Accepts request beats, tags them by kind and buffers them for the core.
// ---------------------------------------------------------------------------
module xs_front #(
	parameter int DEPTH = xs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [63:0]            s_axis_tdata,  // [63:0] seed_value
	input  logic                   s_axis_tuser,  // [0] req_type
	output xs_pkg::q_head_t        head,
	input  logic                   pop
);
	import xs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	req_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;

	assign s_axis_tready = (count_q != CNT_W'(DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;

	assign head.valid   = (count_q != '0);
	assign head.is_next = mem_q[rd_ptr_q].is_next;
	assign head.seed    = mem_q[rd_ptr_q].seed;

	// store payload, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].is_next <= (s_axis_tuser == REQ_NEXT);
			mem_q[wr_ptr_q].seed    <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

endmodule

/* src/xs_seed.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xs_seed - splitmix64 seeding sequencer
// Expands one seed into four state words, one 32x32 partial product a cycle.
// ---------------------------------------------------------------------------
module xs_seed (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      seed,
	output logic             busy,
	output xs_pkg::seed_wr_t wr
);
	import xs_pkg::*;

	sd_state_t        state_q;
	logic [63:0]      acc_q;
	logic [63:0]      x_q;
	logic [63:0]      p_q;
	logic [1:0]       step_q;
	logic [IDX_W-1:0] idx_q;

	logic [63:0] acc_add;
	logic [63:0] mul_k;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;
	logic        mul_phase;

	assign acc_add   = acc_q + SM_GAMMA;
	assign mul_phase = state_q inside {SD_MUL1, SD_MUL2};
	assign mul_k     = (state_q == SD_MUL2) ? SM_MUL2 : SM_MUL1;

	// low*low, high*low, low*high; the high*high term falls off the top
	assign op_a = (step_q == 2'd1) ? x_q[63:32] : x_q[31:0];
	assign op_b = (step_q == 2'd2) ? mul_k[63:32] : mul_k[31:0];
	assign prod = {32'd0, op_a} * {32'd0, op_b};

	assign busy    = (state_q != SD_IDLE);
	assign wr.en   = (state_q == SD_STORE);
	assign wr.idx  = idx_q;
	assign wr.word = p_q ^ (p_q >> SM_SH3);

	// datapath, no reset needed but the accumulator starts from seed zero
	always_ff @(posedge clk) begin
		case (state_q)
			SD_ADD: begin
				x_q <= acc_add ^ (acc_add >> SM_SH1);
			end
			SD_MIX: begin
				x_q <= p_q ^ (p_q >> SM_SH2);
			end
			SD_MUL1, SD_MUL2: begin
				if (step_q == 2'd0) begin
					p_q <= prod;
				end else begin
					p_q[63:32] <= p_q[63:32] + prod[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	// seed zero expansion runs straight out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SD_ADD;
			acc_q   <= '0;
			idx_q   <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				SD_IDLE: begin
					if (start) begin
						acc_q   <= seed;
						idx_q   <= '0;
						state_q <= SD_ADD;
					end
				end
				SD_ADD: begin
					acc_q   <= acc_add;
					step_q  <= '0;
					state_q <= SD_MUL1;
				end
				SD_MUL1: begin
					if (step_q == 2'd2) begin
						step_q  <= '0;
						state_q <= SD_MIX;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				SD_MIX: begin
					state_q <= SD_MUL2;
				end
				SD_MUL2: begin
					if (step_q == 2'd2) begin
						step_q  <= '0;
						state_q <= SD_STORE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				SD_STORE: begin
					if (idx_q == IDX_W'(NWORDS - 1)) begin
						state_q <= SD_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= SD_ADD;
					end
				end
				default: begin
					state_q <= SD_IDLE;
				end
			endcase
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("seeding state not one-hot");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mul_phase |-> (step_q <= 2'd2))
		else $error("multiply step out of range");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == SD_ADD && idx_q == '0))
		else $error("seeding did not restart at word zero");

endmodule

/* src/xs_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xs_back - generator core
// Holds the state words, executes queued requests and scrambles output words.
// ---------------------------------------------------------------------------
module xs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  xs_pkg::q_head_t head,
	output logic            pop,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [63:0]     m_axis_tdata   // [63:0] random_word
);
	import xs_pkg::*;

	logic [63:0] gen_q [NWORDS];

	logic        seed_busy;
	seed_wr_t    seed_wr;
	logic        seed_start;

	logic        v_s1;
	logic [63:0] m5_s1;
	logic        v_s2;
	logic [63:0] word_s2;

	logic        adv2;
	logic        s1_free;
	logic        pop_next;

	logic [63:0] t_sh;
	logic [63:0] n0;
	logic [63:0] n1;
	logic [63:0] n2;
	logic [63:0] n3;
	logic [63:0] rot_s1;

	xs_seed u_seed (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seed_start),
		.seed   (head.seed),
		.busy   (seed_busy),
		.wr     (seed_wr)
	);

	assign adv2     = v_s1 && (!v_s2 || m_axis_tready);
	assign s1_free  = !v_s1 || adv2;
	assign pop      = head.valid && !seed_busy && (!head.is_next || s1_free);
	assign pop_next = pop && head.is_next;
	assign seed_start = pop && !head.is_next;

	// xoshiro256 update
	assign t_sh = gen_q[1] << XS_SHIFT;
	assign n2   = gen_q[2] ^ gen_q[0];
	assign n3   = gen_q[3] ^ gen_q[1];
	assign n1   = gen_q[1] ^ n2;
	assign n0   = gen_q[0] ^ n3;

	assign rot_s1 = {m5_s1[63-SCR_ROT:0], m5_s1[63:64-SCR_ROT]};

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = word_s2;

	always_ff @(posedge clk) begin
		if (seed_wr.en) begin
			gen_q[seed_wr.idx] <= seed_wr.word;
		end else if (pop_next) begin
			gen_q[0] <= n0;
			gen_q[1] <= n1;
			gen_q[2] <= n2 ^ t_sh;
			gen_q[3] <= {n3[63-XS_ROT:0], n3[63:64-XS_ROT]};
		end
		if (pop_next) begin
			m5_s1 <= (gen_q[1] << 2) + gen_q[1];
		end
		if (adv2) begin
			word_s2 <= (rot_s1 << 3) + rot_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (pop_next) begin
				v_s1 <= 1'b1;
			end else if (adv2) begin
				v_s1 <= 1'b0;
			end
			if (adv2) begin
				v_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	a_no_pop_seeding: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && seed_busy))
		else $error("request executed during seeding");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		seed_wr.en |-> (seed_busy && !pop_next))
		else $error("seed write outside seeding");

	a_next_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pop_next |=> v_s1)
		else $error("next request lost before scrambler");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop_next |-> s1_free)
		else $error("scrambler stage overrun");

endmodule

/* src/xoshiro256ss_generator_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xoshiro256ss_generator_unit - xoshiro256** random word generator
// Reseed requests expand a 64-bit seed with splitmix64 into the four state
// words; next requests return rotl(s1*5,7)*9 and advance the state.
// ---------------------------------------------------------------------------
//
// channel   dir  handshake                      payload
// -------   ---  -----------------------------  ------------------------------
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: seed_value, tuser: req_type
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: random_word
//
// Next requests run at one beat per cycle while m_axis is ready and no reseed is
// running: the state update is combinational xor logic, and the scrambler is
// two registered adder stages. A reseed holds the core for four splitmix64
// rounds of add, multiply, mix, multiply and store, with the shared 32x32
// multiplier taking one partial product a cycle. After reset the same seeding
// pass runs with seed zero; requests are queued meanwhile (up to the queue
// depth) but not executed. A stalled m_axis holds the scrambler; the queue
// keeps taking beats until it is full, then drops s_axis_tready.
//
module xoshiro256ss_generator_unit #(
	parameter int QUEUE_DEPTH = xs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] seed_value
	input  logic        s_axis_tuser,   // [0] req_type (0 reseed, 1 next)
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // [63:0] random_word
);
	import xs_pkg::*;

	// head of the request queue and its pop strobe
	q_head_t q_head;
	logic    q_pop;

	// front: accept, classify and buffer requests
	xs_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.head          (q_head),
		.pop           (q_pop)
	);

	// back: state words, seeding sequencer and output scrambler
	xs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

/* tb/xoshiro256ss_generator_unit_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xoshiro256ss_generator_unit_test - self-checking bench for the generator
// Streams reseed and next requests into the block with random gaps and
// output stalls. A model of splitmix64 seeding and the xoshiro256** step
// predicts every random word. Each output beat is checked against the
// oldest prediction still waiting.
// ---------------------------------------------------------------------------
module xoshiro256ss_generator_unit_test;

	typedef logic [xs_pkg::WORD_W-1:0] word_t;

	localparam int CLK_PERIOD   = 12;
	localparam int ITEM_COUNT   = 1100;
	// Output beat count at which the long receiver hold starts, and its length.
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 300;
	// Cycles to let pass after the last result, to cover a trailing reseed.
	localparam int DRAIN_CYCLES = 100;
	// Longest stretch with no beat on either side before the run is abandoned.
	// The worst correct case is the long hold plus a seeding pass and a gap.
	localparam int STALL_LIMIT  = 2000;
	localparam int PRINT_CAP    = 50;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;   // [63:0] seed_value
	logic        s_axis_tuser  = 1'b0; // [0] req_type (0 reseed, 1 next)
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;         // [63:0] random_word

	// Requests waiting to be sent, and random words waiting to come out.
	xs_pkg::req_t pending_reqs[$];
	word_t        expected_words[$];

	// Generator state as the block should hold it.
	word_t gen_state [xs_pkg::NWORDS];

	int unsigned items_sent;
	int unsigned beats_out;
	int unsigned send_wait;
	int unsigned recv_wait;
	int unsigned hold_left;
	int unsigned idle_cycles;
	int unsigned error_count = 0;
	logic        hold_active;
	logic        hold_done;

	xoshiro256ss_generator_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------------
	// Generator model
	// ---------------------------------------------------------------------
	function automatic word_t rotl64(word_t v, int unsigned n);
		return (v << n) | (v >> (xs_pkg::WORD_W - n));
	endfunction

	// Expand a seed into all four state words with splitmix64 rounds.
	function automatic void splitmix_fill(word_t seed);
		word_t acc;
		word_t z;
		acc = seed;
		for (int i = 0; i < xs_pkg::NWORDS; i++) begin
			acc = acc + xs_pkg::SM_GAMMA;
			z = acc;
			z = (z ^ (z >> xs_pkg::SM_SH1)) * xs_pkg::SM_MUL1;
			z = (z ^ (z >> xs_pkg::SM_SH2)) * xs_pkg::SM_MUL2;
			gen_state[i] = z ^ (z >> xs_pkg::SM_SH3);
		end
	endfunction

	// Scramble word 1 into the output, then advance the state.
	function automatic word_t xoshiro_step();
		word_t word;
		word_t t;
		word = rotl64(gen_state[1] * 64'd5, xs_pkg::SCR_ROT) * 64'd9;
		t = gen_state[1] << xs_pkg::XS_SHIFT;
		gen_state[2] = gen_state[2] ^ gen_state[0];
		gen_state[3] = gen_state[3] ^ gen_state[1];
		gen_state[1] = gen_state[1] ^ gen_state[2];
		gen_state[0] = gen_state[0] ^ gen_state[3];
		gen_state[2] = gen_state[2] ^ t;
		gen_state[3] = rotl64(gen_state[3], xs_pkg::XS_ROT);
		return word;
	endfunction

	// ---------------------------------------------------------------------
	// Helpers
	// ---------------------------------------------------------------------
	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	// Mix of plain random seeds and corner seeds: zero, all ones, one hot, one cold.
	function automatic word_t pick_seed();
		word_t one_hot;
		one_hot = word_t'(1) << $urandom_range(0, xs_pkg::WORD_W - 1);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return one_hot;
			3: return ~one_hot;
			default: return rand_word();
		endcase
	endfunction

	// Stretches of 96 beats out of every 288 run with no idling at all.
	function automatic bit calm_phase(int unsigned n);
		return ((n / 96) % 3) == 0;
	endfunction

	function automatic int unsigned pick_wait();
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic push_req(logic kind, word_t seed);
		xs_pkg::req_t r;
		r.is_next = kind;
		r.seed    = seed;
		pending_reqs.push_back(r);
	endtask

	task automatic report_error(string what, word_t got, word_t want);
		if (error_count < PRINT_CAP)
			$display("ERROR at beat %0d: %s got %h want %h", beats_out, what, got, want);
		error_count++;
	endtask

	// ---------------------------------------------------------------------
	// Driver: offer requests, predict on every accepted beat
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : driver
		xs_pkg::req_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= xs_pkg::REQ_RESEED;
			send_wait     <= 0;
			items_sent    <= 0;
			// After reset the block holds the expansion of seed zero.
			splitmix_fill('0);
			expected_words.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == xs_pkg::REQ_NEXT)
					expected_words.push_back(xoshiro_step());
				else
					splitmix_fill(s_axis_tdata);
				items_sent <= items_sent + 1;
			end
			// Move on only once the current beat is gone.
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_wait != 0) begin
					s_axis_tvalid <= 1'b0;
					send_wait     <= send_wait - 1;
				end else if (pending_reqs.size() != 0) begin
					nxt = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= nxt.seed;
					s_axis_tuser  <= nxt.is_next;
					// Keep offering back to back while the receiver holds off.
					send_wait <= (hold_active || calm_phase(items_sent)) ? 0 : pick_wait();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: check result beats, stall the output at random
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : monitor
		word_t       want;
		int unsigned w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_wait     <= 0;
			hold_left     <= 0;
			hold_active   <= 1'b0;
			hold_done     <= 1'b0;
			beats_out     <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					report_error("result beat with nothing expected", m_axis_tdata, '0);
				end else begin
					want = expected_words.pop_front();
					if (m_axis_tdata !== want)
						report_error("random_word", m_axis_tdata, want);
				end
				beats_out <= beats_out + 1;
			end
			if (!hold_done && beats_out == HOLD_AT) begin
				// Hold off long enough for the request queue to fill and stall.
				hold_done     <= 1'b1;
				hold_active   <= 1'b1;
				hold_left     <= HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (hold_active) begin
				if (hold_left == 0) begin
					hold_active   <= 1'b0;
					m_axis_tready <= 1'b1;
				end else begin
					hold_left <= hold_left - 1;
				end
			end else if (m_axis_tvalid && m_axis_tready) begin
				w = calm_phase(beats_out) ? 0 : pick_wait();
				recv_wait     <= w;
				m_axis_tready <= (w == 0);
			end else if (recv_wait != 0) begin
				recv_wait     <= recv_wait - 1;
				m_axis_tready <= (recv_wait == 1);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog: abandon the run when no beat moves for too long
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------------
	initial begin
		int unsigned run_len;

		// Next requests straight out of reset use the seed-zero state.
		push_req(xs_pkg::REQ_NEXT, '0);
		push_req(xs_pkg::REQ_NEXT, '0);
		push_req(xs_pkg::REQ_NEXT, '1);  // seed field is ignored on a next
		// Reseed with zero must restart the reset sequence.
		push_req(xs_pkg::REQ_RESEED, '0);
		push_req(xs_pkg::REQ_NEXT, 64'h0123_4567_89ab_cdef);
		push_req(xs_pkg::REQ_NEXT, '0);
		push_req(xs_pkg::REQ_RESEED, '1);
		push_req(xs_pkg::REQ_NEXT, '0);
		push_req(xs_pkg::REQ_RESEED, 64'd1);
		push_req(xs_pkg::REQ_NEXT, '1);
		push_req(xs_pkg::REQ_RESEED, 64'h8000_0000_0000_0000);
		push_req(xs_pkg::REQ_NEXT, '0);
		// Back-to-back reseeds: only the second one counts.
		push_req(xs_pkg::REQ_RESEED, 64'haaaa_aaaa_aaaa_aaaa);
		push_req(xs_pkg::REQ_RESEED, 64'h5555_5555_5555_5555);
		push_req(xs_pkg::REQ_NEXT, 64'haaaa_aaaa_aaaa_aaaa);
		push_req(xs_pkg::REQ_NEXT, 64'h5555_5555_5555_5555);
		// The first splitmix round lands on zero, so state word 0 is zero.
		push_req(xs_pkg::REQ_RESEED, word_t'(0) - xs_pkg::SM_GAMMA);
		push_req(xs_pkg::REQ_NEXT, '0);
		push_req(xs_pkg::REQ_NEXT, '0);
		push_req(xs_pkg::REQ_NEXT, '0);

		// Mostly long runs of next requests, broken up by reseeds.
		while (pending_reqs.size() < ITEM_COUNT) begin
			if ($urandom_range(0, 11) == 0) begin
				push_req(xs_pkg::REQ_RESEED, pick_seed());
				if ($urandom_range(0, 7) == 0)
					push_req(xs_pkg::REQ_RESEED, pick_seed());
				run_len = $urandom_range(1, 40);
				repeat (run_len) push_req(xs_pkg::REQ_NEXT, rand_word());
			end else begin
				push_req(xs_pkg::REQ_NEXT, rand_word());
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go in and every word to come out.
		@(posedge clk);
		while (pending_reqs.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
